FILE: sv/sorr_pkg.sv
// ============================================================================
// sorr_pkg
// Shared types and constants of the ratio-of-ratios saturation estimator.
// ============================================================================
`default_nettype none

package sorr_pkg;

	// Field widths of the channels and the configuration port.
	localparam int SAMPLE_W = 16;
	localparam int TOTAL_W  = 24;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;

	// Long division unit: dividend and divisor widths.
	localparam int DVD_W  = 40;
	localparam int DVS_W  = 32;
	localparam int STEP_W = $clog2(DVD_W + 1);

	// The quotient is limited to this value before the subtraction.
	localparam int Q_W = 10;
	localparam logic [Q_W-1:0] Q_LIMIT = 10'd1000;

	// Signed working width of intercept minus quotient.
	localparam int V_W = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] INTERCEPT_RST = 8'd110;
	localparam logic [CFG_W-1:0] SLOPE_RST     = 8'd25;
	localparam logic [CFG_W-1:0] FLOOR_RST     = 8'd70;
	localparam logic [CFG_W-1:0] CEILING_RST   = 8'd100;

	// Configuration as seen by the back end.
	typedef struct packed {
		logic [CFG_W-1:0] intercept;
		logic [CFG_W-1:0] slope;
		logic [CFG_W-1:0] floor_percent;
		logic [CFG_W-1:0] ceiling_percent;
	} cfg_t;

	// Summary of one finished run, handed from front to back.
	typedef struct packed {
		logic [TOTAL_W-1:0]  ir_total;
		logic [TOTAL_W-1:0]  red_total;
		logic [COUNT_W-1:0]  count;
		logic [SAMPLE_W-1:0] ir_ac;
		logic [SAMPLE_W-1:0] red_ac;
	} run_sum_t;

	typedef struct packed {
		logic     valid;
		run_sum_t sum;
	} run_push_t;

	// Request to and response from the long division unit.
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic             rem_nz;
	} div_rsp_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IR_GO,
		ST_IR_WAIT,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_CHECK,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_Q_GO,
		ST_Q_WAIT,
		ST_CLAMP,
		ST_EMIT
	} back_state_t;

endpackage

`default_nettype wire

FILE: sv/sorr_in_if.sv
// ============================================================================
// sorr_in_if
// Sample pair channel: valid/ready handshake with one IR/red pair per item.
// ============================================================================
`default_nettype none

interface sorr_in_if;
	logic                          valid;
	logic                          ready;
	logic [sorr_pkg::SAMPLE_W-1:0] ir_sample;
	logic [sorr_pkg::SAMPLE_W-1:0] red_sample;
	logic                          last_sample;

	modport source (output valid, output ir_sample, output red_sample,
		output last_sample, input ready);
	modport sink (input valid, input ir_sample, input red_sample,
		input last_sample, output ready);
endinterface

`default_nettype wire

FILE: sv/sorr_out_if.sv
// ============================================================================
// sorr_out_if
// Result channel: valid/ready handshake with one saturation estimate per item.
// ============================================================================
`default_nettype none

interface sorr_out_if;
	logic                       valid;
	logic                       ready;
	logic [sorr_pkg::CFG_W-1:0] saturation;
	logic                       no_signal;

	modport source (output valid, output saturation, output no_signal, input ready);
	modport sink (input valid, input saturation, input no_signal, output ready);
endinterface

`default_nettype wire

FILE: sv/sorr_front.sv
// ============================================================================
// sorr_front
// Run accumulator: tracks min, max and sum of both channels and hands a
// summary of each finished run to the queue.
// ============================================================================
`default_nettype none

module sorr_front #(
	parameter int MAX_SAMPLES = 255
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	sorr_in_if.sink             samples,
	input  wire logic           fifo_full,
	output sorr_pkg::run_push_t push
);

	logic [sorr_pkg::COUNT_W-1:0]  count_q, count_n;
	logic [sorr_pkg::SAMPLE_W-1:0] ir_low_q, ir_high_q, red_low_q, red_high_q;
	logic [sorr_pkg::SAMPLE_W-1:0] ir_low_n, ir_high_n, red_low_n, red_high_n;
	logic [sorr_pkg::TOTAL_W-1:0]  ir_total_q, red_total_q, ir_total_n, red_total_n;
	logic                          accept;
	logic                          run_end;

	assign samples.ready = !fifo_full;
	assign accept = samples.valid && samples.ready;

	// Running statistics including the current pair.
	always_comb begin
		ir_high_n  = (samples.ir_sample > ir_high_q) ? samples.ir_sample : ir_high_q;
		ir_low_n   = (samples.ir_sample < ir_low_q) ? samples.ir_sample : ir_low_q;
		red_high_n = (samples.red_sample > red_high_q) ? samples.red_sample : red_high_q;
		red_low_n  = (samples.red_sample < red_low_q) ? samples.red_sample : red_low_q;
		ir_total_n  = ir_total_q + sorr_pkg::TOTAL_W'(samples.ir_sample);
		red_total_n = red_total_q + sorr_pkg::TOTAL_W'(samples.red_sample);
		count_n = count_q + 1'b1;
		run_end = samples.last_sample
			|| (count_n >= sorr_pkg::COUNT_W'(MAX_SAMPLES));
	end

	// Summary of the run that this pair closes.
	always_comb begin
		push.valid         = accept && run_end;
		push.sum.ir_total  = ir_total_n;
		push.sum.red_total = red_total_n;
		push.sum.count     = count_n;
		push.sum.ir_ac     = ir_high_n - ir_low_n;
		push.sum.red_ac    = red_high_n - red_low_n;
	end

	// Accumulator registers; cleared when a run closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ir_low_q    <= '1;
			ir_high_q   <= '0;
			red_low_q   <= '1;
			red_high_q  <= '0;
			ir_total_q  <= '0;
			red_total_q <= '0;
		end else if (accept) begin
			if (run_end) begin
				count_q     <= '0;
				ir_low_q    <= '1;
				ir_high_q   <= '0;
				red_low_q   <= '1;
				red_high_q  <= '0;
				ir_total_q  <= '0;
				red_total_q <= '0;
			end else begin
				count_q     <= count_n;
				ir_low_q    <= ir_low_n;
				ir_high_q   <= ir_high_n;
				red_low_q   <= red_low_n;
				red_high_q  <= red_high_n;
				ir_total_q  <= ir_total_n;
				red_total_q <= red_total_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/sorr_run_fifo.sv
// ============================================================================
// sorr_run_fifo
// Two-entry queue of run summaries between the accumulator and the back end.
// ============================================================================
`default_nettype none

module sorr_run_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  sorr_pkg::run_push_t      push,
	input  wire logic                pop,
	output logic                     full,
	output logic                     not_empty,
	output sorr_pkg::run_sum_t       head
);

	sorr_pkg::run_sum_t entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.sum;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push.valid && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push.valid) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/sorr_divider.sv
// ============================================================================
// sorr_divider
// Restoring long division, one quotient bit per cycle, shared by all three
// divisions of a run.
// ============================================================================
`default_nettype none

module sorr_divider (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  sorr_pkg::div_req_t  req,
	output sorr_pkg::div_rsp_t  rsp
);

	logic [sorr_pkg::DVD_W-1:0]  quo_q;
	logic [sorr_pkg::DVS_W-1:0]  rem_q;
	logic [sorr_pkg::DVS_W-1:0]  dvs_q;
	logic [sorr_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [sorr_pkg::DVS_W:0]    trial;
	logic [sorr_pkg::DVS_W+1:0]  diff;
	logic                        qbit;

	// One step: bring down the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, quo_q[sorr_pkg::DVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		qbit  = !diff[sorr_pkg::DVS_W+1];
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = (rem_q != '0);

	// Datapath: remainder and shifting quotient register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[sorr_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[sorr_pkg::DVS_W-1:0] : trial[sorr_pkg::DVS_W-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == sorr_pkg::STEP_W'(sorr_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/sorr_back.sv
// ============================================================================
// sorr_back
// Run evaluator: forms DC levels, the ratio of ratios and the clamped
// saturation estimate, and drives the result register.
// ============================================================================
`default_nettype none

module sorr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  sorr_pkg::cfg_t     cfg,
	input  wire logic          fifo_not_empty,
	input  sorr_pkg::run_sum_t fifo_head,
	output logic               pop,
	sorr_out_if.source         results
);

	sorr_pkg::back_state_t state_q, state_n;
	sorr_pkg::run_sum_t    run_q;
	sorr_pkg::div_req_t    div_req;
	sorr_pkg::div_rsp_t    div_rsp;

	logic [sorr_pkg::SAMPLE_W-1:0]   ir_dc_q, red_dc_q;
	logic [2*sorr_pkg::SAMPLE_W-1:0] part_q, den_q;
	logic [sorr_pkg::DVD_W-1:0]      num_q;
	logic [sorr_pkg::Q_W-1:0]        q_q, q_n;
	logic [sorr_pkg::CFG_W-1:0]      res_sat_q;
	logic                            res_ns_q;
	logic                            out_valid_q;
	logic [sorr_pkg::CFG_W-1:0]      out_sat_q;
	logic                            out_ns_q;
	logic                            no_sig;
	logic signed [sorr_pkg::V_W-1:0] v_raw, v_hi, v_lo, v_ceil, v_floor;
	logic                            out_free;

	sorr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_free = !out_valid_q || results.ready;

	// Special cases and clamping arithmetic.
	always_comb begin
		no_sig = (ir_dc_q == '0) || (red_dc_q == '0)
			|| ((run_q.ir_ac == '0) && (run_q.red_ac == '0));
		if (div_rsp.quotient >= sorr_pkg::DVD_W'(sorr_pkg::Q_LIMIT)) begin
			q_n = sorr_pkg::Q_LIMIT;
		end else begin
			q_n = div_rsp.quotient[sorr_pkg::Q_W-1:0] + sorr_pkg::Q_W'(div_rsp.rem_nz);
		end
		v_raw   = $signed(sorr_pkg::V_W'(cfg.intercept)) - $signed(sorr_pkg::V_W'(q_q));
		v_ceil  = $signed(sorr_pkg::V_W'(cfg.ceiling_percent));
		v_floor = $signed(sorr_pkg::V_W'(cfg.floor_percent));
		v_hi    = (v_raw > v_ceil) ? v_ceil : v_raw;
		v_lo    = (v_hi < v_floor) ? v_floor : v_hi;
	end

	// Sequencer: next state, queue pop and divider requests.
	always_comb begin
		state_n          = state_q;
		pop              = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sorr_pkg::DVD_W'(run_q.ir_total);
		div_req.divisor  = sorr_pkg::DVS_W'(run_q.count);
		case (state_q)
			sorr_pkg::ST_IDLE: begin
				if (fifo_not_empty) begin
					pop     = 1'b1;
					state_n = sorr_pkg::ST_IR_GO;
				end
			end
			sorr_pkg::ST_IR_GO: begin
				div_req.start = 1'b1;
				state_n       = sorr_pkg::ST_IR_WAIT;
			end
			sorr_pkg::ST_IR_WAIT: begin
				if (div_rsp.done) begin
					state_n = sorr_pkg::ST_RED_GO;
				end
			end
			sorr_pkg::ST_RED_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = sorr_pkg::DVD_W'(run_q.red_total);
				state_n          = sorr_pkg::ST_RED_WAIT;
			end
			sorr_pkg::ST_RED_WAIT: begin
				if (div_rsp.done) begin
					state_n = sorr_pkg::ST_CHECK;
				end
			end
			sorr_pkg::ST_CHECK: begin
				if (no_sig || (run_q.ir_ac == '0)) begin
					state_n = sorr_pkg::ST_EMIT;
				end else begin
					state_n = sorr_pkg::ST_MUL_A;
				end
			end
			sorr_pkg::ST_MUL_A: begin
				state_n = sorr_pkg::ST_MUL_B;
			end
			sorr_pkg::ST_MUL_B: begin
				state_n = sorr_pkg::ST_MUL_C;
			end
			sorr_pkg::ST_MUL_C: begin
				state_n = sorr_pkg::ST_Q_GO;
			end
			sorr_pkg::ST_Q_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = num_q;
				div_req.divisor  = den_q;
				state_n          = sorr_pkg::ST_Q_WAIT;
			end
			sorr_pkg::ST_Q_WAIT: begin
				if (div_rsp.done) begin
					state_n = sorr_pkg::ST_CLAMP;
				end
			end
			sorr_pkg::ST_CLAMP: begin
				state_n = sorr_pkg::ST_EMIT;
			end
			sorr_pkg::ST_EMIT: begin
				if (out_free) begin
					state_n = sorr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sorr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sorr_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Working registers of the current run.
	always_ff @(posedge clk) begin
		if (pop) begin
			run_q <= fifo_head;
		end
		if ((state_q == sorr_pkg::ST_IR_WAIT) && div_rsp.done) begin
			ir_dc_q <= div_rsp.quotient[sorr_pkg::SAMPLE_W-1:0];
		end
		if ((state_q == sorr_pkg::ST_RED_WAIT) && div_rsp.done) begin
			red_dc_q <= div_rsp.quotient[sorr_pkg::SAMPLE_W-1:0];
		end
		if (state_q == sorr_pkg::ST_CHECK) begin
			if (no_sig) begin
				res_sat_q <= '0;
				res_ns_q  <= 1'b1;
			end else begin
				res_sat_q <= cfg.floor_percent;
				res_ns_q  <= 1'b0;
			end
		end
		if (state_q == sorr_pkg::ST_MUL_A) begin
			part_q <= run_q.red_ac * ir_dc_q;
		end
		if (state_q == sorr_pkg::ST_MUL_B) begin
			den_q <= red_dc_q * run_q.ir_ac;
		end
		if (state_q == sorr_pkg::ST_MUL_C) begin
			num_q <= sorr_pkg::DVD_W'(cfg.slope) * sorr_pkg::DVD_W'(part_q);
		end
		if ((state_q == sorr_pkg::ST_Q_WAIT) && div_rsp.done) begin
			q_q <= q_n;
		end
		if (state_q == sorr_pkg::ST_CLAMP) begin
			res_sat_q <= v_lo[sorr_pkg::CFG_W-1:0];
			res_ns_q  <= 1'b0;
		end
	end

	// Result register toward the receiver.
	always_ff @(posedge clk) begin
		if ((state_q == sorr_pkg::ST_EMIT) && out_free) begin
			out_sat_q <= res_sat_q;
			out_ns_q  <= res_ns_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == sorr_pkg::ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.saturation = out_sat_q;
	assign results.no_signal  = out_ns_q;

endmodule

`default_nettype wire

FILE: sv/spo2_ratio_of_ratios_core.sv
// ============================================================================
// spo2_ratio_of_ratios_core
// Ratio-of-ratios oxygen saturation estimator, top level.
//
// Usage: IR/red sample pairs arrive on the samples channel (valid/ready), one
// item per pair; last_sample closes a run, and a run also closes on its
// MAX_SAMPLES-th pair. Each run yields one item on the results channel:
// the clamped saturation estimate, or zero with no_signal set.
// The accumulator takes one pair per cycle while the two-entry run queue has
// room. The evaluator works on one run at a time: three passes of the shared
// 40-step long divider (IR DC, red DC, ratio) plus sequencing, multiply and
// clamp states; no signal or a flat IR channel skips the ratio. Runs that
// close faster than the evaluator finishes them back up into the queue.
// The result sits in an output register. A stalled receiver holds it, the
// evaluator then waits with the next result, and once two more runs fill the
// queue the samples channel drops ready.
// Reset (arst_n low) clears the run, empties the queue, drops any pending
// result and loads the default configuration. Configuration writes through
// cfg_we/cfg_index/cfg_wdata take effect at once; the user makes them while
// idle, and the block itself does not enforce this.
// ============================================================================
`default_nettype none

module spo2_ratio_of_ratios_core #(
	parameter int MAX_SAMPLES = 255
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sorr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sorr_pkg::CFG_W-1:0]     cfg_wdata,
	sorr_in_if.sink                             samples,
	sorr_out_if.source                          results
);

	sorr_pkg::cfg_t      cfg_q;
	sorr_pkg::run_push_t push;
	sorr_pkg::run_sum_t  head;
	logic                fifo_full;
	logic                fifo_not_empty;
	logic                pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.intercept       <= sorr_pkg::INTERCEPT_RST;
			cfg_q.slope           <= sorr_pkg::SLOPE_RST;
			cfg_q.floor_percent   <= sorr_pkg::FLOOR_RST;
			cfg_q.ceiling_percent <= sorr_pkg::CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sorr_pkg::REG_INTERCEPT: cfg_q.intercept       <= cfg_wdata;
				sorr_pkg::REG_SLOPE:     cfg_q.slope           <= cfg_wdata;
				sorr_pkg::REG_FLOOR:     cfg_q.floor_percent   <= cfg_wdata;
				sorr_pkg::REG_CEILING:   cfg_q.ceiling_percent <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	sorr_front #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.fifo_full (fifo_full),
		.push      (push)
	);

	sorr_run_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.full      (fifo_full),
		.not_empty (fifo_not_empty),
		.head      (head)
	);

	sorr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.fifo_not_empty (fifo_not_empty),
		.fifo_head      (head),
		.pop            (pop),
		.results        (results)
	);

endmodule

`default_nettype wire

FILE: dv/spo2_ratio_of_ratios_core_test.sv
// ============================================================================
// spo2_ratio_of_ratios_core_test
// Self-checking testbench for the ratio-of-ratios saturation estimator.
//
// IR/red sample pairs are driven in runs on the samples channel. A predictor
// in the testbench keeps its own per-run minimum, maximum and sums, works out
// the estimate of every closed run and queues it. Each item on the results
// channel is checked field by field against the oldest queued estimate.
// Directed runs cover the no-signal cases, the clamping corners, the run
// length limit and the register extremes. Random runs with random idling on
// both channels and one long output stall make up the bulk of the traffic.
// ============================================================================

module spo2_ratio_of_ratios_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sorr_pkg::*;

	localparam int RUN_LIMIT      = 255;
	localparam int TOTAL_ITEMS    = 1950;
	localparam int QUIET_ITEMS    = 200;
	localparam int SETTLE_CYCLES  = 200;
	localparam int HOLD_CYCLES    = 2000;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [CFG_W-1:0] saturation;
		logic             no_signal;
	} estimate_t;

	typedef enum {
		RUN_PHYSIO,
		RUN_WIDE,
		RUN_TINY,
		RUN_FLAT_IR,
		RUN_EXTREME
	} run_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	sorr_in_if  sample_ch ();
	sorr_out_if result_ch ();

	// Predictor state: configuration and the statistics of the open run.
	cfg_t                sat_cfg;
	logic [COUNT_W-1:0]  pair_count;
	logic [SAMPLE_W-1:0] ir_min;
	logic [SAMPLE_W-1:0] ir_max;
	logic [SAMPLE_W-1:0] red_min;
	logic [SAMPLE_W-1:0] red_max;
	logic [TOTAL_W-1:0]  ir_sum;
	logic [TOTAL_W-1:0]  red_sum;
	estimate_t           pending_estimates [$];

	int error_count = 0;
	int items_sent = 0;
	int idle_pct = 0;
	int hold_request = 0;
	int quiet_cycles = 0;

	spo2_ratio_of_ratios_core #(
		.MAX_SAMPLES(RUN_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.samples  (sample_ch),
		.results  (result_ch)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Start a fresh run in the predictor.
	function automatic void clear_run_state();
		pair_count = '0;
		ir_min = '1;
		ir_max = '0;
		red_min = '1;
		red_max = '0;
		ir_sum = '0;
		red_sum = '0;
	endfunction

	// Expected estimate of the run held in the predictor state.
	function automatic estimate_t estimate_saturation();
		logic [63:0] pairs;
		logic [63:0] ir_dc;
		logic [63:0] red_dc;
		logic [63:0] ir_ac;
		logic [63:0] red_ac;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quot;
		int          v;
		estimate_t   est;

		pairs = (pair_count == 0) ? 64'd1 : 64'(pair_count);
		ir_dc = 64'(ir_sum) / pairs;
		red_dc = 64'(red_sum) / pairs;
		ir_ac = 64'(ir_max) - 64'(ir_min);
		red_ac = 64'(red_max) - 64'(red_min);
		est.saturation = '0;
		est.no_signal = 1'b0;
		if (ir_dc == 0 || red_dc == 0 || (ir_ac == 0 && red_ac == 0)) begin
			est.no_signal = 1'b1;
		end else if (ir_ac == 0) begin
			// The ratio is unbounded, so the estimate sits on the floor.
			est.saturation = sat_cfg.floor_percent;
		end else begin
			num = 64'(sat_cfg.slope) * red_ac * ir_dc;
			den = red_dc * ir_ac;
			quot = (num + den - 1) / den;
			if (quot > 64'(Q_LIMIT))
				quot = 64'(Q_LIMIT);
			v = int'(sat_cfg.intercept) - int'(quot);
			// Ceiling first, then floor: the floor wins when they cross.
			if (v > int'(sat_cfg.ceiling_percent))
				v = int'(sat_cfg.ceiling_percent);
			if (v < int'(sat_cfg.floor_percent))
				v = int'(sat_cfg.floor_percent);
			est.saturation = CFG_W'(v);
		end
		return est;
	endfunction

	// Fold one accepted pair into the run; a closed run queues its estimate.
	function automatic void accumulate_pair(logic [SAMPLE_W-1:0] ir,
		logic [SAMPLE_W-1:0] red, logic last);
		if (ir > ir_max)
			ir_max = ir;
		if (ir < ir_min)
			ir_min = ir;
		if (red > red_max)
			red_max = red;
		if (red < red_min)
			red_min = red;
		ir_sum = ir_sum + TOTAL_W'(ir);
		red_sum = red_sum + TOTAL_W'(red);
		pair_count = pair_count + 1'b1;
		if (last || pair_count >= RUN_LIMIT) begin
			pending_estimates.push_back(estimate_saturation());
			clear_run_state();
		end
	endfunction

	// Offer one pair, with an optional idle burst first, until it is taken.
	task automatic send_pair(input logic [SAMPLE_W-1:0] ir,
		input logic [SAMPLE_W-1:0] red, input logic last);
		int gap;

		gap = 0;
		if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
			gap = $urandom_range(1, 16);
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.ir_sample = ir;
		sample_ch.red_sample = red;
		sample_ch.last_sample = last;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
		accumulate_pair(ir, red, last);
		items_sent++;
	endtask

	// Let the block drain: no pair offered, every estimate delivered.
	task automatic wait_idle();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(posedge clk);
		case (index)
			REG_INTERCEPT: sat_cfg.intercept = value;
			REG_SLOPE:     sat_cfg.slope = value;
			REG_FLOOR:     sat_cfg.floor_percent = value;
			REG_CEILING:   sat_cfg.ceiling_percent = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(input cfg_t setting);
		wait_idle();
		write_reg(REG_INTERCEPT, setting.intercept);
		write_reg(REG_SLOPE, setting.slope);
		write_reg(REG_FLOOR, setting.floor_percent);
		write_reg(REG_CEILING, setting.ceiling_percent);
	endtask

	// One complete run of random length and random character. A run of the
	// full length may close on the length limit alone.
	task automatic send_random_run();
		int                  len;
		int                  pick;
		int                  i;
		int                  ir_base;
		int                  ir_amp;
		int                  red_base;
		int                  red_amp;
		run_kind_t           kind;
		logic                close;
		logic [SAMPLE_W-1:0] ir;
		logic [SAMPLE_W-1:0] red;

		pick = $urandom_range(1, 100);
		if (pick <= 80)
			len = $urandom_range(1, 12);
		else if (pick <= 97)
			len = $urandom_range(13, 64);
		else
			len = $urandom_range(65, RUN_LIMIT);
		close = (len < RUN_LIMIT) || ($urandom_range(0, 1) == 1);

		pick = $urandom_range(1, 100);
		if (pick <= 60)
			kind = RUN_PHYSIO;
		else if (pick <= 75)
			kind = RUN_WIDE;
		else if (pick <= 85)
			kind = RUN_TINY;
		else if (pick <= 93)
			kind = RUN_FLAT_IR;
		else
			kind = RUN_EXTREME;

		// Pulsatile signal: red swing scaled so the ratio lands near 0.3..2.
		ir_base = $urandom_range(2000, 56000);
		ir_amp = $urandom_range(1, ir_base / 8);
		red_base = $urandom_range(2000, 56000);
		red_amp = int'(longint'(red_base) * ir_amp * $urandom_range(30, 200)
			/ (longint'(ir_base) * 100));
		if (red_amp < 1)
			red_amp = 1;
		if (red_amp > 9000)
			red_amp = 9000;

		for (i = 0; i < len; i++) begin
			case (kind)
				RUN_WIDE: begin
					ir = SAMPLE_W'($urandom_range(0, 65535));
					red = SAMPLE_W'($urandom_range(0, 65535));
				end
				RUN_TINY: begin
					ir = SAMPLE_W'($urandom_range(0, 3));
					red = SAMPLE_W'($urandom_range(0, 3));
				end
				RUN_EXTREME: begin
					ir = ($urandom_range(0, 1) != 0 ? 16'hFFFF : 16'h0000)
						^ SAMPLE_W'($urandom_range(0, 1));
					red = ($urandom_range(0, 1) != 0 ? 16'hFFFF : 16'h0000)
						^ SAMPLE_W'($urandom_range(0, 1));
				end
				default: begin
					if (kind == RUN_FLAT_IR)
						ir = SAMPLE_W'(ir_base);
					else
						ir = SAMPLE_W'(ir_base + $urandom_range(0, ir_amp));
					red = SAMPLE_W'(red_base + $urandom_range(0, red_amp));
				end
			endcase
			send_pair(ir, red, close && (i == len - 1));
		end
	endtask

	// Corner runs at the reset configuration.
	task automatic test_special_cases();
		idle_pct = 15;
		// A single zero pair: both DC levels are zero.
		send_pair(16'h0000, 16'h0000, 1'b1);
		// Flat full-scale run: both AC values are zero.
		send_pair(16'hFFFF, 16'hFFFF, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		// IR mean truncates to zero.
		send_pair(16'd1, 16'd100, 1'b0);
		send_pair(16'd0, 16'd200, 1'b1);
		// Red DC level zero.
		send_pair(16'd100, 16'd0, 1'b0);
		send_pair(16'd200, 16'd0, 1'b1);
		// Only the IR AC is zero: floor.
		send_pair(16'd5000, 16'd4000, 1'b0);
		send_pair(16'd5000, 16'd4200, 1'b1);
		// Typical pulsatile run inside the window.
		send_pair(16'd50000, 16'd30000, 1'b0);
		send_pair(16'd51000, 16'd30300, 1'b0);
		send_pair(16'd50500, 16'd30150, 1'b1);
		// Full swing on both channels.
		send_pair(16'h0000, 16'hFFFF, 1'b0);
		send_pair(16'hFFFF, 16'h0000, 1'b1);
		// Huge ratio: the quotient hits its limit, result clamps to the floor.
		send_pair(16'hFFFE, 16'd1, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		// Only the red AC is zero: intercept clamps to the ceiling.
		send_pair(16'd1000, 16'd2000, 1'b0);
		send_pair(16'd3000, 16'd2000, 1'b1);
	endtask

	// Register extremes, including a floor above the ceiling and a zero slope.
	task automatic test_register_extremes();
		cfg_t corners [5];
		int   k;

		corners[0] = '{8'd0, 8'd0, 8'd0, 8'd0};
		corners[1] = '{8'd255, 8'd255, 8'd255, 8'd255};
		corners[2] = '{8'd255, 8'd0, 8'd0, 8'd255};
		corners[3] = '{8'd200, 8'd25, 8'd90, 8'd40};
		corners[4] = '{8'd0, 8'd255, 8'd0, 8'd255};
		for (k = 0; k < 5; k++) begin
			set_config(corners[k]);
			send_pair(16'd5000, 16'd4000, 1'b0);
			send_pair(16'd5000, 16'd4200, 1'b1);
			send_pair(16'h0000, 16'hFFFF, 1'b0);
			send_pair(16'hFFFF, 16'h0000, 1'b1);
			repeat (6) send_random_run();
		end
		set_config('{INTERCEPT_RST, SLOPE_RST, FLOOR_RST, CEILING_RST});
	endtask

	// A run that never sets last_sample closes on its 255th pair.
	task automatic test_run_length_limit();
		int k;

		idle_pct = 10;
		for (k = 0; k < RUN_LIMIT; k++)
			send_pair(SAMPLE_W'($urandom_range(0, 65535)),
				SAMPLE_W'($urandom_range(0, 65535)), 1'b0);
		// The next pair must start a clean run.
		send_pair(SAMPLE_W'($urandom_range(0, 65535)),
			SAMPLE_W'($urandom_range(0, 65535)), 1'b1);
	endtask

	// Long receiver hold while short runs keep coming, so the input backs up.
	task automatic test_output_stall();
		int k;

		wait_idle();
		idle_pct = 0;
		hold_request = HOLD_CYCLES;
		for (k = 0; k < 40; k++)
			send_pair(SAMPLE_W'($urandom_range(1000, 60000)),
				SAMPLE_W'($urandom_range(1000, 60000)), $urandom_range(0, 1) == 1);
		send_pair(16'd20000, 16'd30000, 1'b1);
		wait_idle();
	endtask

	// Random phases, each with its own configuration and idling level, then a
	// closing stretch with no idling at all.
	task automatic test_random_runs();
		cfg_t setting;
		int   phase_end;

		while (items_sent < TOTAL_ITEMS - QUIET_ITEMS) begin
			setting.intercept = ($urandom_range(0, 9) < 7) ?
				CFG_W'($urandom_range(90, 130)) : CFG_W'($urandom_range(0, 255));
			setting.slope = ($urandom_range(0, 9) < 7) ?
				CFG_W'($urandom_range(10, 40)) : CFG_W'($urandom_range(0, 255));
			setting.floor_percent = ($urandom_range(0, 9) < 7) ?
				CFG_W'($urandom_range(50, 80)) : CFG_W'($urandom_range(0, 255));
			setting.ceiling_percent = ($urandom_range(0, 9) < 7) ?
				CFG_W'($urandom_range(95, 110)) : CFG_W'($urandom_range(0, 255));
			set_config(setting);
			idle_pct = 15 * $urandom_range(0, 2);
			phase_end = items_sent + $urandom_range(150, 350);
			while (items_sent < phase_end)
				send_random_run();
		end
		idle_pct = 0;
		while (items_sent < TOTAL_ITEMS)
			send_random_run();
	endtask

	// Result receiver: random stall bursts, plus the long hold on request.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				result_ch.ready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
				result_ch.ready = 1'b0;
				repeat ($urandom_range(1, 16) - 1) @(negedge clk);
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	// Check each delivered estimate against the oldest expected one.
	initial begin
		estimate_t want;

		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_estimates.size() == 0) begin
					$error("unexpected result item: saturation %0d, no_signal %0b",
						result_ch.saturation, result_ch.no_signal);
					error_count++;
				end else begin
					want = pending_estimates.pop_front();
					if (result_ch.saturation !== want.saturation) begin
						$error("saturation: expected %0d, actual %0d",
							want.saturation, result_ch.saturation);
						error_count++;
					end
					if (result_ch.no_signal !== want.no_signal) begin
						$error("no_signal: expected %0b, actual %0b",
							want.no_signal, result_ch.no_signal);
						error_count++;
					end
				end
			end
		end
	end

	// Watchdog: too many cycles in a row with no item moving on either channel.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) ||
				(result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Reset, then the tests in turn, then drain and report.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_INTERCEPT;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.ir_sample = '0;
		sample_ch.red_sample = '0;
		sample_ch.last_sample = 1'b0;
		sat_cfg = '{INTERCEPT_RST, SLOPE_RST, FLOOR_RST, CEILING_RST};
		clear_run_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_special_cases();
		test_register_extremes();
		test_run_length_limit();
		test_output_stall();
		test_random_runs();
		wait_idle();

		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
sv/sorr_pkg.sv
sv/sorr_in_if.sv
sv/sorr_out_if.sv
sv/sorr_front.sv
sv/sorr_run_fifo.sv
sv/sorr_divider.sv
sv/sorr_back.sv
sv/spo2_ratio_of_ratios_core.sv
dv/spo2_ratio_of_ratios_core_test.sv
